// File: rtl/rnu_pkg.sv
package rnu_pkg;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_CHECK,
        ST_GCD_WAIT,
        ST_NUM_WAIT,
        ST_DEN_START,
        ST_DEN_WAIT,
        ST_FINISH
    } state_t;

    typedef enum logic [1:0] {
        OP_GCD,
        OP_NUM,
        OP_DEN
    } div_op_t;

    typedef struct packed {
        logic    load;
        logic    div_start;
        logic    div_take;
        logic    out_load;
        div_op_t op;
    } ctrl_cmd_t;

    typedef struct packed {
        logic nmag_zero;
        logic b_zero;
        logic div_busy;
        logic div_done;
    } dp_status_t;

endpackage

// File: rtl/rnu_div.sv
module rnu_div #(
    parameter int WIDTH = 32
) (
    input  logic             aclk,
    input  logic             aresetn,
    input  logic             start,
    input  logic [WIDTH-1:0] dividend,
    input  logic [WIDTH-1:0] divisor,
    output logic             busy,
    output logic             done,
    output logic [WIDTH-1:0] quotient,
    output logic [WIDTH-1:0] remainder
);

    localparam int CW = $clog2(WIDTH + 1);

    logic             busy_reg, busy_next;
    logic             done_reg, done_next;
    logic [CW-1:0]    cnt_reg, cnt_next;
    logic [WIDTH-1:0] rem_reg, rem_next;
    logic [WIDTH-1:0] quo_reg, quo_next;
    logic [WIDTH-1:0] dvs_reg, dvs_next;
    logic [WIDTH:0]   trial;

    // restoring division, one quotient bit per cycle
    assign trial = {rem_reg, quo_reg[WIDTH-1]} - {1'b0, dvs_reg};

    always_comb begin
        busy_next = busy_reg;
        done_next = 1'b0;
        cnt_next  = cnt_reg;
        rem_next  = rem_reg;
        quo_next  = quo_reg;
        dvs_next  = dvs_reg;
        if (start && !busy_reg) begin
            busy_next = 1'b1;
            cnt_next  = CW'(WIDTH);
            rem_next  = '0;
            quo_next  = dividend;
            dvs_next  = divisor;
        end else if (busy_reg) begin
            if (!trial[WIDTH]) begin
                rem_next = trial[WIDTH-1:0];
                quo_next = {quo_reg[WIDTH-2:0], 1'b1};
            end else begin
                rem_next = {rem_reg[WIDTH-2:0], quo_reg[WIDTH-1]};
                quo_next = {quo_reg[WIDTH-2:0], 1'b0};
            end
            cnt_next = cnt_reg - CW'(1);
            if (cnt_reg == CW'(1)) begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
        end else begin
            busy_reg <= busy_next;
            done_reg <= done_next;
        end
        cnt_reg <= cnt_next;
        rem_reg <= rem_next;
        quo_reg <= quo_next;
        dvs_reg <= dvs_next;
    end

    assign busy      = busy_reg;
    assign done      = done_reg;
    assign quotient  = quo_reg;
    assign remainder = rem_reg;

endmodule

// File: rtl/rnu_datapath.sv
module rnu_datapath #(
    parameter int DATA_WIDTH = 32
) (
    input  logic                       aclk,
    input  logic                       aresetn,
    input  rnu_pkg::ctrl_cmd_t         cmd,
    output rnu_pkg::dp_status_t        sts,
    input  logic [DATA_WIDTH-1:0]      num_in,
    input  logic [DATA_WIDTH-1:0]      den_in,
    output logic [DATA_WIDTH-1:0]      num_out,
    output logic [DATA_WIDTH-2:0]      den_out
);

    logic [DATA_WIDTH-1:0] nmag_reg, nmag_next;
    logic [DATA_WIDTH-1:0] dmag_reg, dmag_next;
    logic                  neg_reg, neg_next;
    logic [DATA_WIDTH-1:0] a_reg, a_next;
    logic [DATA_WIDTH-1:0] b_reg, b_next;
    logic [DATA_WIDTH-1:0] qn_reg, qn_next;
    logic [DATA_WIDTH-1:0] qd_reg, qd_next;
    logic [DATA_WIDTH-1:0] num_out_reg, num_out_next;
    logic [DATA_WIDTH-2:0] den_out_reg, den_out_next;

    logic [DATA_WIDTH-1:0] nmag_in, dmag_in;
    logic [DATA_WIDTH-1:0] div_dividend, div_divisor;
    logic [DATA_WIDTH-1:0] div_quo, div_rem;
    logic                  div_busy, div_done;

    // magnitude is exact in DATA_WIDTH unsigned bits, most negative included
    assign nmag_in = num_in[DATA_WIDTH-1] ? (~num_in + 1'b1) : num_in;
    assign dmag_in = den_in[DATA_WIDTH-1] ? (~den_in + 1'b1) : den_in;

    always_comb begin
        case (cmd.op)
            rnu_pkg::OP_GCD: begin
                div_dividend = a_reg;
                div_divisor  = b_reg;
            end
            rnu_pkg::OP_NUM: begin
                div_dividend = nmag_reg;
                div_divisor  = a_reg;
            end
            rnu_pkg::OP_DEN: begin
                div_dividend = dmag_reg;
                div_divisor  = a_reg;
            end
            default: begin
                div_dividend = a_reg;
                div_divisor  = b_reg;
            end
        endcase
    end

    rnu_div #(
        .WIDTH (DATA_WIDTH)
    ) u_div (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .start     (cmd.div_start),
        .dividend  (div_dividend),
        .divisor   (div_divisor),
        .busy      (div_busy),
        .done      (div_done),
        .quotient  (div_quo),
        .remainder (div_rem)
    );

    always_comb begin
        nmag_next    = nmag_reg;
        dmag_next    = dmag_reg;
        neg_next     = neg_reg;
        a_next       = a_reg;
        b_next       = b_reg;
        qn_next      = qn_reg;
        qd_next      = qd_reg;
        num_out_next = num_out_reg;
        den_out_next = den_out_reg;
        if (cmd.load) begin
            nmag_next = nmag_in;
            dmag_next = dmag_in;
            neg_next  = num_in[DATA_WIDTH-1] ^ den_in[DATA_WIDTH-1];
            a_next    = nmag_in;
            b_next    = dmag_in;
        end
        if (cmd.div_take) begin
            case (cmd.op)
                rnu_pkg::OP_GCD: begin
                    a_next = b_reg;
                    b_next = div_rem;
                end
                rnu_pkg::OP_NUM: qn_next = div_quo;
                rnu_pkg::OP_DEN: qd_next = div_quo;
                default: begin
                    a_next = a_reg;
                end
            endcase
        end
        if (cmd.out_load) begin
            if (nmag_reg == '0) begin
                num_out_next = '0;
                den_out_next = {{(DATA_WIDTH-2){1'b0}}, 1'b1};
            end else begin
                num_out_next = neg_reg ? (~qn_reg + 1'b1) : qn_reg;
                // saturate the denominator at the largest positive value
                den_out_next = qd_reg[DATA_WIDTH-1] ? '1 : qd_reg[DATA_WIDTH-2:0];
            end
        end
    end

    always_ff @(posedge aclk) begin
        nmag_reg    <= nmag_next;
        dmag_reg    <= dmag_next;
        neg_reg     <= neg_next;
        a_reg       <= a_next;
        b_reg       <= b_next;
        qn_reg      <= qn_next;
        qd_reg      <= qd_next;
        num_out_reg <= num_out_next;
        den_out_reg <= den_out_next;
    end

    assign sts.nmag_zero = (nmag_reg == '0);
    assign sts.b_zero    = (b_reg == '0);
    assign sts.div_busy  = div_busy;
    assign sts.div_done  = div_done;

    assign num_out = num_out_reg;
    assign den_out = den_out_reg;

endmodule

// File: rtl/rnu_ctrl.sv
module rnu_ctrl (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                s_valid,
    output logic                s_ready,
    output logic                m_valid,
    input  logic                m_ready,
    input  rnu_pkg::dp_status_t sts,
    output rnu_pkg::ctrl_cmd_t  cmd
);

    rnu_pkg::state_t state_reg, state_next;
    logic            m_valid_reg, m_valid_next;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= rnu_pkg::ST_IDLE;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            m_valid_reg <= m_valid_next;
        end
    end

    always_comb begin
        state_next   = state_reg;
        cmd          = '0;
        cmd.op       = rnu_pkg::OP_GCD;
        s_ready      = 1'b0;
        m_valid_next = m_valid_reg && !m_ready;
        case (state_reg)
            rnu_pkg::ST_IDLE: begin
                s_ready = 1'b1;
                if (s_valid) begin
                    cmd.load   = 1'b1;
                    state_next = rnu_pkg::ST_CHECK;
                end
            end
            rnu_pkg::ST_CHECK: begin
                if (sts.nmag_zero) begin
                    state_next = rnu_pkg::ST_FINISH;
                end else if (sts.b_zero) begin
                    // remainder chain ended, gcd sits in a
                    cmd.op        = rnu_pkg::OP_NUM;
                    cmd.div_start = 1'b1;
                    state_next    = rnu_pkg::ST_NUM_WAIT;
                end else begin
                    cmd.op        = rnu_pkg::OP_GCD;
                    cmd.div_start = 1'b1;
                    state_next    = rnu_pkg::ST_GCD_WAIT;
                end
            end
            rnu_pkg::ST_GCD_WAIT: begin
                cmd.op = rnu_pkg::OP_GCD;
                if (sts.div_done) begin
                    cmd.div_take = 1'b1;
                    state_next   = rnu_pkg::ST_CHECK;
                end
            end
            rnu_pkg::ST_NUM_WAIT: begin
                cmd.op = rnu_pkg::OP_NUM;
                if (sts.div_done) begin
                    cmd.div_take = 1'b1;
                    state_next   = rnu_pkg::ST_DEN_START;
                end
            end
            rnu_pkg::ST_DEN_START: begin
                cmd.op        = rnu_pkg::OP_DEN;
                cmd.div_start = 1'b1;
                state_next    = rnu_pkg::ST_DEN_WAIT;
            end
            rnu_pkg::ST_DEN_WAIT: begin
                cmd.op = rnu_pkg::OP_DEN;
                if (sts.div_done) begin
                    cmd.div_take = 1'b1;
                    state_next   = rnu_pkg::ST_FINISH;
                end
            end
            rnu_pkg::ST_FINISH: begin
                // wait for the output register to free up
                if (!m_valid_reg || m_ready) begin
                    cmd.out_load = 1'b1;
                    m_valid_next = 1'b1;
                    state_next   = rnu_pkg::ST_IDLE;
                end
            end
            default: begin
                state_next = rnu_pkg::ST_IDLE;
            end
        endcase
    end

    assign m_valid = m_valid_reg;

endmodule

// File: rtl/rational_normalizer_unit.sv
// rational_normalizer_unit: reduces a signed fraction to canonical form
// slave beat: s_axis_tdata carries numerator and denominator (two's complement);
// master beat: m_axis_tdata carries the reduced numerator (sign of the fraction)
// and the non-negative reduced denominator; zero numerator gives 0/1, zero
// denominator gives +1/0 or -1/0
// one item is processed at a time: s_axis_tready is high only while the unit is
// idle, but a finished result may still sit in the output register then
// all division goes through one shared restoring divider, one quotient bit per
// cycle; the gcd takes one division per euclidean remainder step (at most about
// 46 for 32-bit operands), then numerator and denominator are each divided by
// the gcd; a zero numerator skips the divider
// reset (aresetn low, synchronous) returns the controller to idle and drops
// m_axis_tvalid; an item in flight is lost
// when the receiver stalls, the result holds in the output register and the
// unit finishes at most one more item, then waits until the beat is taken
module rational_normalizer_unit #(
    parameter int DATA_WIDTH = 32
) (
    input  logic                                  aclk,
    input  logic                                  aresetn,
    input  logic                                  s_axis_tvalid,
    output logic                                  s_axis_tready,
    // numerator_in, denominator_in
    input  logic [((2*DATA_WIDTH+7)/8)*8-1:0]     s_axis_tdata,
    output logic                                  m_axis_tvalid,
    input  logic                                  m_axis_tready,
    // numerator_out, denominator_out, zero pad
    output logic [((2*DATA_WIDTH+6)/8)*8-1:0]     m_axis_tdata
);

    localparam int OUT_W = ((2*DATA_WIDTH+6)/8)*8;
    localparam int PAD_W = OUT_W - (2*DATA_WIDTH-1);

    rnu_pkg::ctrl_cmd_t  cmd;
    rnu_pkg::dp_status_t sts;
    logic [DATA_WIDTH-1:0] num_out;
    logic [DATA_WIDTH-2:0] den_out;

    rnu_ctrl u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_axis_tvalid),
        .s_ready (s_axis_tready),
        .m_valid (m_axis_tvalid),
        .m_ready (m_axis_tready),
        .sts     (sts),
        .cmd     (cmd)
    );

    rnu_datapath #(
        .DATA_WIDTH (DATA_WIDTH)
    ) u_dp (
        .aclk    (aclk),
        .aresetn (aresetn),
        .cmd     (cmd),
        .sts     (sts),
        .num_in  (s_axis_tdata[DATA_WIDTH-1:0]),
        .den_in  (s_axis_tdata[2*DATA_WIDTH-1:DATA_WIDTH]),
        .num_out (num_out),
        .den_out (den_out)
    );

    assign m_axis_tdata = {{PAD_W{1'b0}}, den_out, num_out};

    // the shared divider is never restarted while it is still iterating
    assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.div_start |-> !sts.div_busy)
        else $error("divider started while busy");

    // a division result only appears right after the divider was iterating
    assert property (@(posedge aclk) disable iff (!aresetn)
        sts.div_done |-> $past(sts.div_busy))
        else $error("divider done without a running division");

    // a zero denominator only comes with a unit numerator
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_axis_tvalid && (den_out == '0) |->
            (num_out == {{(DATA_WIDTH-1){1'b0}}, 1'b1}) || (num_out == '1))
        else $error("zero denominator with non-unit numerator");

    // a zero numerator always comes out over one
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_axis_tvalid && (num_out == '0) |->
            (den_out == {{(DATA_WIDTH-2){1'b0}}, 1'b1}))
        else $error("zero numerator not over one");

endmodule
